// ----- rtl/core/hpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// hpsd_pkg: shared types and constants of the pulse stream Huffman decoder
// Item layouts, table sizes, status codes and the back end state encodings.
// ----------------------------------------------------------------------------
package hpsd_pkg;

    // Table sizes
    localparam int NODE_DEPTH  = 32768;
    localparam int NODE_AW     = $clog2(NODE_DEPTH);
    localparam int NODE_CW     = NODE_AW + 1;          // node count, holds NODE_DEPTH
    localparam int NODE_EW     = NODE_CW + 1;          // leaf flag + payload
    localparam int LEAF_DEPTH  = NODE_DEPTH / 2 + 1;
    localparam int LEAF_AW     = $clog2(LEAF_DEPTH);
    localparam int LEAF_CW     = LEAF_AW;              // leaf count
    localparam int STACK_DEPTH = 64;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int SP_W        = STACK_AW + 1;
    localparam int MAX_SYMBOLS = 131072;
    localparam int CNT_W       = 18;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Result status codes
    localparam logic [1:0] ST_SYMBOL     = 2'd0;
    localparam logic [1:0] ST_NODES_FULL = 2'd1;
    localparam logic [1:0] ST_STACK_OVF  = 2'd2;
    localparam logic [1:0] ST_LONE_LEAF  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } in_item_t;

    typedef struct packed {
        logic [15:0] symbol_value;
        logic        last;
        logic [1:0]  status;
    } out_item_t;

    // Queue entry kinds, set by the front end
    typedef enum logic {
        KIND_BYTE,
        KIND_START
    } q_kind_t;

    typedef struct packed {
        q_kind_t    kind;
        logic [7:0] data;
    } q_item_t;

    // Stream phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SHAPE,
        PH_VALUES,
        PH_DATA,
        PH_DONE
    } phase_t;

    // Back end sequencer
    typedef enum logic [2:0] {
        E_FETCH,
        E_SHAPE,
        E_POP,
        E_DATA,
        E_STEP,
        E_LEAF,
        E_ERR
    } eng_state_t;

endpackage

// ----- rtl/core/hpsd_ram.sv -----
// ----------------------------------------------------------------------------
// hpsd_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hpsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/hpsd_queue.sv -----
// ----------------------------------------------------------------------------
// hpsd_queue: short item queue between front and back end
// Register based FIFO; head item is shown combinationally.
// ----------------------------------------------------------------------------
module hpsd_queue
    import hpsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t wdata,
    input  logic    pop,
    output q_item_t head,
    output logic    empty,
    output logic    full
);

    q_item_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/core/hpsd_front.sv -----
// ----------------------------------------------------------------------------
// hpsd_front: input item acceptance and classification
// Marks stream starts, drops the header byte after the start, queues the rest.
// ----------------------------------------------------------------------------
module hpsd_front
    import hpsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  in_item_t item,
    input  logic     q_full,
    output logic     q_push,
    output q_item_t  q_wdata
);

    logic hdr_pending_reg;
    logic hdr_pending_next;
    logic accept;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    // Classify the accepted item
    always_comb
    begin
        hdr_pending_next = hdr_pending_reg;
        q_push           = 1'b0;
        q_wdata.kind     = KIND_BYTE;
        q_wdata.data     = item.data_byte;
        if (accept)
        begin
            if (item.start_req)
            begin
                // start byte is header byte 0, one more header byte follows
                q_push           = 1'b1;
                q_wdata.kind     = KIND_START;
                hdr_pending_next = 1'b1;
            end
            else if (hdr_pending_reg)
            begin
                hdr_pending_next = 1'b0;
            end
            else
            begin
                q_push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pending_reg <= 1'b0;
        end
        else
        begin
            hdr_pending_reg <= hdr_pending_next;
        end
    end

endmodule

// ----- rtl/core/hpsd_back.sv -----
// ----------------------------------------------------------------------------
// hpsd_back: tree build, leaf value load and bit-serial tree walk
// Sequencer over node, leaf value and pending stack RAMs plus result register.
// ----------------------------------------------------------------------------
module hpsd_back
    import hpsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    input  q_item_t          q_head,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             result_valid,
    input  logic             result_stall,
    output out_item_t        result
);

    eng_state_t            state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [SP_W-1:0]       sp_reg, sp_next;
    logic [NODE_CW-1:0]    nodes_reg, nodes_next;
    logic [LEAF_CW-1:0]    lbuilt_reg, lbuilt_next;
    logic [LEAF_CW-1:0]    lloaded_reg, lloaded_next;
    logic                  half_valid_reg, half_valid_next;
    logic [7:0]            half_byte_reg, half_byte_next;
    logic [7:0]            byte_reg, byte_next;
    logic [2:0]            bit_reg, bit_next;
    logic [NODE_AW-1:0]    cur_reg, cur_next;
    logic [NODE_CW-1:0]    cur_right_reg, cur_right_next;
    logic [NODE_CW-1:0]    root_right_reg, root_right_next;
    logic [NODE_AW-1:0]    walk_reg, walk_next;
    logic [CNT_W-1:0]      symbols_reg, symbols_next;
    logic [CNT_W-1:0]      count_reg;
    logic [1:0]            err_reg, err_next;
    logic                  leaf_ok_reg, leaf_ok_next;
    logic                  out_valid_reg;
    out_item_t             out_item_reg;

    // RAM ports
    logic                  node_we, node_re;
    logic [NODE_AW-1:0]    node_waddr, node_raddr;
    logic [NODE_EW-1:0]    node_wdata, node_rdata;
    logic                  stk_we, stk_re;
    logic [STACK_AW-1:0]   stk_waddr, stk_raddr;
    logic [NODE_AW-1:0]    stk_wdata, stk_rdata;
    logic                  leaf_we, leaf_re;
    logic [LEAF_AW-1:0]    leaf_waddr, leaf_raddr;
    logic [15:0]           leaf_wdata, leaf_rdata;

    // Shared decode
    logic                  cur_bit;
    logic [CNT_W-1:0]      limit;
    logic                  out_free;
    logic                  out_load;
    out_item_t             out_item_next;
    logic                  shape_full, shape_lone, shape_ovf;
    logic [LEAF_CW-1:0]    lloaded_inc;
    logic                  node_is_leaf;
    logic [NODE_CW-1:0]    node_payload;
    logic                  fin;

    assign cur_bit      = byte_reg[3'd7 - bit_reg];
    assign limit        = (count_reg > CNT_W'(MAX_SYMBOLS)) ? CNT_W'(MAX_SYMBOLS) : count_reg;
    assign out_free     = !out_valid_reg || !result_stall;
    assign shape_full   = (nodes_reg >= NODE_CW'(NODE_DEPTH));
    assign shape_lone   = cur_bit && (nodes_reg == '0);
    assign shape_ovf    = !cur_bit && (sp_reg >= SP_W'(STACK_DEPTH));
    assign lloaded_inc  = lloaded_reg + 1'b1;
    assign node_is_leaf = node_rdata[NODE_EW-1];
    assign node_payload = node_rdata[NODE_CW-1:0];
    assign fin          = (symbols_reg >= limit);
    assign walk_next    = cur_bit ? cur_right_reg[NODE_AW-1:0] : cur_reg + 1'b1;

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // Next state and datapath registers
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        sp_next         = sp_reg;
        nodes_next      = nodes_reg;
        lbuilt_next     = lbuilt_reg;
        lloaded_next    = lloaded_reg;
        half_valid_next = half_valid_reg;
        half_byte_next  = half_byte_reg;
        byte_next       = byte_reg;
        bit_next        = bit_reg;
        cur_next        = cur_reg;
        cur_right_next  = cur_right_reg;
        root_right_next = root_right_reg;
        symbols_next    = symbols_reg;
        err_next        = err_reg;
        leaf_ok_next    = leaf_ok_reg;
        case (state_reg)
            E_FETCH:
            begin
                if (!q_empty)
                begin
                    if (q_head.kind == KIND_START)
                    begin
                        sp_next         = '0;
                        nodes_next      = '0;
                        lbuilt_next     = '0;
                        lloaded_next    = '0;
                        half_valid_next = 1'b0;
                        cur_next        = '0;
                        symbols_next    = '0;
                        phase_next      = PH_SHAPE;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_SHAPE:
                            begin
                                byte_next  = q_head.data;
                                bit_next   = '0;
                                state_next = E_SHAPE;
                            end
                            PH_VALUES:
                            begin
                                if (!half_valid_reg)
                                begin
                                    half_valid_next = 1'b1;
                                    half_byte_next  = q_head.data;
                                end
                                else
                                begin
                                    half_valid_next = 1'b0;
                                    lloaded_next    = lloaded_inc;
                                    if (lloaded_inc >= lbuilt_reg)
                                    begin
                                        // data phase at root; done if limit 0
                                        cur_next       = '0;
                                        cur_right_next = root_right_reg;
                                        symbols_next   = '0;
                                        phase_next     = (limit == '0) ? PH_DONE : PH_DATA;
                                    end
                                end
                            end
                            PH_DATA:
                            begin
                                if (fin)
                                begin
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    byte_next  = q_head.data;
                                    bit_next   = '0;
                                    state_next = E_DATA;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            E_SHAPE:
            begin
                if (shape_full || shape_lone || shape_ovf)
                begin
                    err_next   = shape_full ? ST_NODES_FULL :
                                 (shape_lone ? ST_LONE_LEAF : ST_STACK_OVF);
                    phase_next = PH_DONE;
                    state_next = E_ERR;
                end
                else if (cur_bit)
                begin
                    lbuilt_next = lbuilt_reg + 1'b1;
                    nodes_next  = nodes_reg + 1'b1;
                    if (sp_reg == '0)
                    begin
                        // tree complete, rest of byte dropped
                        phase_next      = PH_VALUES;
                        lloaded_next    = '0;
                        half_valid_next = 1'b0;
                        state_next      = E_FETCH;
                    end
                    else
                    begin
                        sp_next    = sp_reg - 1'b1;
                        state_next = E_POP;
                    end
                end
                else
                begin
                    sp_next    = sp_reg + 1'b1;
                    nodes_next = nodes_reg + 1'b1;
                    if (bit_reg == 3'd7)
                    begin
                        state_next = E_FETCH;
                    end
                    else
                    begin
                        bit_next = bit_reg + 1'b1;
                    end
                end
            end
            E_POP:
            begin
                // parent's right child is the next node to be built
                if (stk_rdata == '0)
                begin
                    root_right_next = nodes_reg;
                end
                if (bit_reg == 3'd7)
                begin
                    state_next = E_FETCH;
                end
                else
                begin
                    bit_next   = bit_reg + 1'b1;
                    state_next = E_SHAPE;
                end
            end
            E_DATA:
            begin
                state_next = E_STEP;
            end
            E_STEP:
            begin
                if (node_is_leaf)
                begin
                    leaf_ok_next   = (node_payload < NODE_CW'(LEAF_DEPTH));
                    symbols_next   = symbols_reg + 1'b1;
                    cur_next       = '0;
                    cur_right_next = root_right_reg;
                    state_next     = E_LEAF;
                end
                else
                begin
                    cur_next       = walk_reg;
                    cur_right_next = node_payload;
                    if (bit_reg == 3'd7)
                    begin
                        state_next = E_FETCH;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 1'b1;
                        state_next = E_DATA;
                    end
                end
            end
            E_LEAF:
            begin
                if (out_free)
                begin
                    if (fin)
                    begin
                        phase_next = PH_DONE;
                        state_next = E_FETCH;
                    end
                    else if (bit_reg == 3'd7)
                    begin
                        state_next = E_FETCH;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 1'b1;
                        state_next = E_DATA;
                    end
                end
            end
            E_ERR:
            begin
                if (out_free)
                begin
                    state_next = E_FETCH;
                end
            end
            default:
            begin
                state_next = E_FETCH;
            end
        endcase
    end

    // Outputs: queue pop, RAM controls, result load
    always_comb
    begin
        q_pop         = (state_reg == E_FETCH) && !q_empty;
        node_we       = 1'b0;
        node_waddr    = nodes_reg[NODE_AW-1:0];
        node_wdata    = '0;
        node_re       = 1'b0;
        node_raddr    = walk_next;
        stk_we        = 1'b0;
        stk_waddr     = sp_reg[STACK_AW-1:0];
        stk_wdata     = nodes_reg[NODE_AW-1:0];
        stk_re        = 1'b0;
        stk_raddr     = STACK_AW'(sp_reg - 1'b1);
        leaf_we       = 1'b0;
        leaf_waddr    = lloaded_reg[LEAF_AW-1:0];
        leaf_wdata    = {half_byte_reg, q_head.data};
        leaf_re       = 1'b0;
        leaf_raddr    = node_payload[LEAF_AW-1:0];
        out_load      = 1'b0;
        out_item_next = '0;
        case (state_reg)
            E_FETCH:
            begin
                leaf_we = q_pop && (q_head.kind == KIND_BYTE) && (phase_reg == PH_VALUES)
                          && half_valid_reg && (lloaded_reg < LEAF_CW'(LEAF_DEPTH));
            end
            E_SHAPE:
            begin
                if (!(shape_full || shape_lone || shape_ovf))
                begin
                    node_we = 1'b1;
                    if (cur_bit)
                    begin
                        node_wdata = {1'b1, NODE_CW'(lbuilt_reg)};
                        stk_re     = (sp_reg != '0);
                    end
                    else
                    begin
                        stk_we = 1'b1;
                    end
                end
            end
            E_POP:
            begin
                node_we    = 1'b1;
                node_waddr = stk_rdata;
                node_wdata = {1'b0, nodes_reg};
            end
            E_DATA:
            begin
                node_re = 1'b1;
            end
            E_STEP:
            begin
                leaf_re = node_is_leaf;
            end
            E_LEAF:
            begin
                out_load                   = out_free;
                out_item_next.symbol_value = leaf_ok_reg ? leaf_rdata : 16'd0;
                out_item_next.last         = fin;
                out_item_next.status       = ST_SYMBOL;
            end
            E_ERR:
            begin
                out_load                   = out_free;
                out_item_next.symbol_value = 16'd0;
                out_item_next.last         = 1'b1;
                out_item_next.status       = err_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= E_FETCH;
            phase_reg      <= PH_IDLE;
            sp_reg         <= '0;
            nodes_reg      <= '0;
            lbuilt_reg     <= '0;
            lloaded_reg    <= '0;
            half_valid_reg <= 1'b0;
            bit_reg        <= '0;
            cur_reg        <= '0;
            symbols_reg    <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            sp_reg         <= sp_next;
            nodes_reg      <= nodes_next;
            lbuilt_reg     <= lbuilt_next;
            lloaded_reg    <= lloaded_next;
            half_valid_reg <= half_valid_next;
            bit_reg        <= bit_next;
            cur_reg        <= cur_next;
            symbols_reg    <= symbols_next;
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        half_byte_reg  <= half_byte_next;
        byte_reg       <= byte_next;
        cur_right_reg  <= cur_right_next;
        root_right_reg <= root_right_next;
        err_reg        <= err_next;
        leaf_ok_reg    <= leaf_ok_next;
        if (state_reg == E_DATA)
        begin
            walk_reg <= walk_next;
        end
        if (out_load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    hpsd_ram #(
        .WIDTH (NODE_EW),
        .DEPTH (NODE_DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    hpsd_ram #(
        .WIDTH (NODE_AW),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    hpsd_ram #(
        .WIDTH (16),
        .DEPTH (LEAF_DEPTH)
    ) u_leaf_ram (
        .clk   (clk),
        .we    (leaf_we),
        .waddr (leaf_waddr),
        .wdata (leaf_wdata),
        .re    (leaf_re),
        .raddr (leaf_raddr),
        .rdata (leaf_rdata)
    );

endmodule

// ----- rtl/core/huffman_pulse_stream_decoder.sv -----
// Flow: accepted items, bar the dropped header byte, are queued and popped in the back end's
//   fetch state; each data bit is a node RAM read then a step; a symbol ends in the leaf state.
// The back end takes no new byte from the queue until it is through with the current one. A
//   shape byte steps through its bits with a pop after each completed subtree; start and value
//   bytes are taken in the fetch state. Decoding speed is set by the node RAM read per tree step.
// Reset: control state cleared asynchronously; tables hold no reset value, no clearing pass.
// ----------------------------------------------------------------------------
// huffman_pulse_stream_decoder: top level of the pulse stream Huffman decoder
// Front end classifies items, queue decouples, back end builds and walks the tree.
// ----------------------------------------------------------------------------
module huffman_pulse_stream_decoder
    import hpsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  in_item_t         item,
    output logic             result_valid,
    input  logic             result_stall,
    output out_item_t        result,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data
);

    logic    q_push;
    q_item_t q_wdata;
    logic    q_pop;
    q_item_t q_head;
    logic    q_empty;
    logic    q_full;

    hpsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    hpsd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .head  (q_head),
        .empty (q_empty),
        .full  (q_full)
    );

    hpsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .q_head       (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the pulse stream Huffman decoder
// Builds random preorder trees, streams header, shape, leaf values and data
// bytes, predicts each decoded symbol and error, and checks every result.
// ----------------------------------------------------------------------------
module tb_top;
    import hpsd_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    in_item_t         item;
    logic             result_valid;
    logic             result_stall;
    out_item_t        result;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_data;

    huffman_pulse_stream_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    // Predictor state
    typedef enum int { M_IDLE, M_HEADER, M_SHAPE, M_VALUES, M_DATA, M_DONE } mphase_t;
    logic [16:0] m_nodes [NODE_DEPTH];
    logic [15:0] m_leaf_val [LEAF_DEPTH];
    int          m_stack [STACK_DEPTH];
    int          m_sp, m_nodes_built, m_leaves_built, m_leaves_loaded, m_cur, m_done_cnt;
    int          m_hdr;
    logic [8:0]  m_half;
    mphase_t     m_phase;
    int          m_count;

    out_item_t   expected_results[$];
    int          fail_count;
    bit          quiet;
    int          cycles;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("huffman_pulse_stream_decoder regression: fail");
            $finish;
        end
    end

    function automatic int limit_count();
        return (m_count > MAX_SYMBOLS) ? MAX_SYMBOLS : m_count;
    endfunction

    function automatic void push_error(logic [1:0] st);
        out_item_t r;
        r.symbol_value = '0;
        r.last = 1'b1;
        r.status = st;
        expected_results.push_back(r);
        m_phase = M_DONE;
    endfunction

    // Work out the results of one accepted item
    function automatic void predict_decode(logic [7:0] b, logic st);
        logic [16:0] ent, lf;
        int nxt, li;
        out_item_t r;
        if (st)
        begin
            m_sp = 0; m_nodes_built = 0; m_leaves_built = 0; m_leaves_loaded = 0;
            m_half = '0; m_cur = 0; m_done_cnt = 0; m_hdr = 1; m_phase = M_HEADER;
            return;
        end
        case (m_phase)
            M_HEADER:
            begin
                m_hdr = (m_hdr + 1) & 3;
                if (m_hdr >= 2) m_phase = M_SHAPE;
            end
            M_SHAPE:
                for (int i = 7; i >= 0; i--)
                begin
                    if (m_nodes_built >= NODE_DEPTH)
                    begin
                        push_error(ST_NODES_FULL);
                        return;
                    end
                    if (b[i])
                    begin
                        if (m_nodes_built == 0)
                        begin
                            push_error(ST_LONE_LEAF);
                            return;
                        end
                        m_nodes[m_nodes_built] = {1'b1, 16'(m_leaves_built)};
                        m_leaves_built++;
                        m_nodes_built++;
                        if (m_sp == 0)
                        begin
                            m_phase = M_VALUES;
                            m_leaves_loaded = 0;
                            m_half = '0;
                            return;
                        end
                        m_sp--;
                        m_nodes[m_stack[m_sp]] = {1'b0, 16'(m_nodes_built)};
                    end
                    else
                    begin
                        if (m_sp >= STACK_DEPTH)
                        begin
                            push_error(ST_STACK_OVF);
                            return;
                        end
                        m_nodes[m_nodes_built] = '0;
                        m_stack[m_sp] = m_nodes_built;
                        m_sp++;
                        m_nodes_built++;
                    end
                end
            M_VALUES:
            begin
                if (!m_half[8])
                    m_half = {1'b1, b};
                else
                begin
                    if (m_leaves_loaded < LEAF_DEPTH)
                        m_leaf_val[m_leaves_loaded] = {m_half[7:0], b};
                    m_half = '0;
                    m_leaves_loaded++;
                    if (m_leaves_loaded >= m_leaves_built)
                    begin
                        m_cur = 0;
                        m_done_cnt = 0;
                        m_phase = (limit_count() == 0) ? M_DONE : M_DATA;
                    end
                end
            end
            M_DATA:
            begin
                if (m_done_cnt >= limit_count())
                begin
                    m_phase = M_DONE;
                    return;
                end
                for (int i = 7; i >= 0; i--)
                begin
                    ent = m_nodes[m_cur];
                    nxt = b[i] ? int'(ent[15:0]) : m_cur + 1;
                    nxt = nxt % NODE_DEPTH;
                    lf = m_nodes[nxt];
                    if (lf[16])
                    begin
                        li = int'(lf[15:0]);
                        m_done_cnt++;
                        r.symbol_value = (li < LEAF_DEPTH) ? m_leaf_val[li] : 16'h0;
                        r.last = (m_done_cnt >= limit_count());
                        r.status = ST_SYMBOL;
                        expected_results.push_back(r);
                        m_cur = 0;
                        if (r.last)
                        begin
                            m_phase = M_DONE;
                            return;
                        end
                    end
                    else
                        m_cur = nxt;
                end
            end
            default: ;
        endcase
    endfunction

    // Result checker and receiver stalls
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (result.symbol_value !== e.symbol_value)
                begin
                    $display("%0t: symbol_value expected %h actual %h", $time,
                             e.symbol_value, result.symbol_value);
                    fail_count++;
                end
                if (result.last !== e.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, e.last, result.last);
                    fail_count++;
                end
                if (result.status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             e.status, result.status);
                    fail_count++;
                end
            end
        end
    end

    int stall_left;
    always @(negedge clk)
    begin
        if (quiet)
            result_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 6);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Send one item, sometimes with a random gap before it (never when quiet)
    task automatic send_byte(input logic [7:0] b, input logic st = 1'b0);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        item_valid <= 1'b1;
        item.data_byte <= b;
        item.start_req <= st;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        predict_decode(b, st);
        @(negedge clk);
    endtask

    task automatic drain_and_settle();
        item_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_count(input int n);
        drain_and_settle();
        cfg_we <= 1'b1;
        cfg_data <= n[CNT_W-1:0];
        m_count = n & 32'h3FFFF;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random preorder tree shape bits
    task automatic build_shape(input int max_depth, input int max_leaves, ref bit bits[$]);
        int depth_q[$];
        int d, leaves;
        bits.delete();
        bits.push_back(0);
        depth_q.push_back(1);
        depth_q.push_back(1);
        leaves = 0;
        while (depth_q.size() > 0)
        begin
            d = depth_q.pop_back();
            if (d >= max_depth || leaves + depth_q.size() + 1 >= max_leaves
                || $urandom_range(0, 2) == 0)
            begin
                bits.push_back(1);
                leaves++;
            end
            else
            begin
                bits.push_back(0);
                depth_q.push_back(d + 1);
                depth_q.push_back(d + 1);
            end
        end
    endtask

    // One whole track: header, shape, values, data
    task automatic send_track(input int max_depth, input int max_leaves, input int data_bytes);
        bit bits[$];
        logic [7:0] b;
        int nl;
        build_shape(max_depth, max_leaves, bits);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_byte(8'($urandom_range(0, 255)));
        for (int i = 0; i < bits.size(); i += 8)
        begin
            b = 8'($urandom_range(0, 255));
            for (int j = 0; j < 8 && i + j < bits.size(); j++) b[7-j] = bits[i+j];
            send_byte(b);
        end
        nl = 0;
        foreach (bits[i]) nl += bits[i];
        for (int i = 0; i < 2 * nl; i++) send_byte(8'($urandom_range(0, 255)));
        for (int i = 0; i < data_bytes; i++) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_directed();
        write_count(3);
        send_byte(8'h55);                   // ignored before any start
        // tree 0 1 1: leaves A and B
        send_byte(8'h00, 1'b1); send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'h5A);                   // 0,1,0,1,1 ...
        send_byte(8'hAA);                   // done: ignored
        // lone leaf
        send_byte(8'h00, 1'b1); send_byte(8'h00); send_byte(8'h80);
        // stack overflow: on the 65th of 72 zero bits
        send_byte(8'h12, 1'b1); send_byte(8'h34);
        for (int i = 0; i < 9; i++) send_byte(8'h00);
        write_count(0);
        send_track(3, 8, 2);
        write_count(20'h3FFFF);             // clamps to the symbol limit
        send_track(4, 16, 4);
    endtask

    task automatic test_random();
        int counts[4] = '{1, 5, 13, 40};
        for (int t = 0; t < 6; t++)
        begin
            if (t % 3 == 0) write_count(counts[$urandom_range(0, 3)]);
            if ($urandom_range(0, 5) == 0)
                for (int i = 0; i < 4; i++)
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                send_track($urandom_range(2, 7), $urandom_range(2, 40),
                           $urandom_range(4, 20));
        end
        quiet = 1'b1;
        write_count(7);
        for (int t = 0; t < 2; t++) send_track(6, 30, 10);
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        fail_count = 0;
        quiet = 1'b0;
        cycles = 0;
        stall_left = 0;
        m_count = 0;
        m_phase = M_IDLE;
        m_sp = 0; m_nodes_built = 0; m_leaves_built = 0; m_leaves_loaded = 0;
        m_cur = 0; m_done_cnt = 0; m_hdr = 0; m_half = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random();
        drain_and_settle();
        if (fail_count == 0)
            $display("huffman_pulse_stream_decoder regression: pass");
        else
            $display("huffman_pulse_stream_decoder regression: fail");
        $finish;
    end
endmodule
